// File: design/gha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int SLOTS_DEF        = 1024;
   localparam int VERSION_BITS_DEF = 16;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_FREE   = 2'd1;
   localparam logic [1:0] FUNC_EXISTS = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_STALE = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  handle_index;
      logic [15:0] handle_version;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  out_index;
      logic [15:0] out_version;
      logic        handle_live;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sweep;
      logic capture;
      logic execute;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
   } sts_type;

endpackage

// File: design/gha_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_datapath
// Version and link memories, free-list head, item register and result register.
// ----------------------------------------------------------------------------
module gha_datapath #(
   parameter int SLOTS        = gha_pkg::SLOTS_DEF,
   parameter int VERSION_BITS = gha_pkg::VERSION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  gha_pkg::cmd_type cmd,
   output gha_pkg::sts_type sts,
   input  gha_pkg::req_type req_data,
   output gha_pkg::rsp_type rsp_data
);

   localparam int IDX_W  = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam int LINK_W = IDX_W + 1;
   localparam int IW     = (IDX_W > 10) ? IDX_W : 10;
   localparam int VW     = (VERSION_BITS > 16) ? VERSION_BITS : 16;
   localparam logic [LINK_W-1:0] END_MARK = LINK_W'(SLOTS);

   logic [VERSION_BITS-1:0] ver_mem  [SLOTS];
   logic [LINK_W-1:0]       link_mem [SLOTS];

   logic [IDX_W-1:0]        sweep_ff, sweep_in;
   logic [LINK_W-1:0]       head_ff, head_in;
   gha_pkg::req_type        req_ff;
   gha_pkg::rsp_type        rsp_ff, rsp_in;
   logic [VERSION_BITS-1:0] ver_rd_ff;
   logic [LINK_W-1:0]       link_rd_ff;

   logic [IDX_W-1:0]        rd_addr;
   logic [IW-1:0]           cap_idx_wide;
   logic [IW-1:0]           req_idx_wide;
   logic [IDX_W-1:0]        req_addr;
   logic [VW-1:0]           req_ver_wide;
   logic [VW-1:0]           rd_ver_wide;
   logic                    in_range;
   logic                    ver_match;
   logic                    list_empty;
   logic                    free_ok;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [VERSION_BITS-1:0] wr_ver;
   logic [LINK_W-1:0]       wr_link;

   // Allocate reads the head slot; free and exists read the handle's slot.
   assign cap_idx_wide = IW'(req_data.handle_index);
   assign rd_addr      = (req_data.func == gha_pkg::FUNC_ALLOC) ? head_ff[IDX_W-1:0]
                                                                : cap_idx_wide[IDX_W-1:0];

   assign req_idx_wide = IW'(req_ff.handle_index);
   assign req_addr     = req_idx_wide[IDX_W-1:0];
   assign req_ver_wide = VW'(req_ff.handle_version);
   assign rd_ver_wide  = VW'(ver_rd_ff);
   assign in_range     = 32'(req_ff.handle_index) < 32'(SLOTS);
   assign ver_match    = in_range && (ver_rd_ff == req_ver_wide[VERSION_BITS-1:0]);
   assign list_empty   = (head_ff == END_MARK);
   assign free_ok      = (req_ff.func == gha_pkg::FUNC_FREE) && ver_match;

   assign sts.sweep_last = (sweep_ff == IDX_W'(SLOTS - 1));

   always_comb begin
      rsp_in  = '0;
      head_in = head_ff;
      case (req_ff.func)
         gha_pkg::FUNC_ALLOC: begin
            if (list_empty) begin
               rsp_in.status = gha_pkg::STATUS_FULL;
            end else begin
               rsp_in.out_index   = 10'(head_ff);
               rsp_in.out_version = rd_ver_wide[15:0];
               head_in            = link_rd_ff;
            end
         end
         gha_pkg::FUNC_FREE: begin
            if (ver_match) begin
               head_in = LINK_W'(req_addr);
            end else begin
               rsp_in.status = gha_pkg::STATUS_STALE;
            end
         end
         gha_pkg::FUNC_EXISTS: begin
            rsp_in.handle_live = ver_match;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // One write port shared by the clearing sweep and a successful free.
   always_comb begin
      wr_en   = cmd.sweep || (cmd.execute && free_ok);
      wr_addr = cmd.sweep ? sweep_ff : req_addr;
      wr_ver  = cmd.sweep ? VERSION_BITS'(1) : ver_rd_ff + VERSION_BITS'(1);
      wr_link = cmd.sweep ? LINK_W'(sweep_ff) + LINK_W'(1) : head_ff;
   end

   assign sweep_in = cmd.sweep ? sweep_ff + IDX_W'(1) : sweep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         head_ff  <= '0;
      end else begin
         sweep_ff <= sweep_in;
         if (cmd.execute) begin
            head_ff <= head_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ver_mem[wr_addr]  <= wr_ver;
         link_mem[wr_addr] <= wr_link;
      end
      if (cmd.capture) begin
         ver_rd_ff  <= ver_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
         req_ff     <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: design/gha_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_controller
// Sequencer for the clearing sweep, item capture, execution and result hold.
// ----------------------------------------------------------------------------
module gha_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gha_pkg::cmd_type cmd,
   input  gha_pkg::sts_type sts
);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.sweep   = (state_ff == ST_INIT);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = (state_ff == ST_EXEC) && out_free;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_blocks_next: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_ready)
      else $error("item accepted in back-to-back cycles");

   a_execute_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid)
      else $error("executed item did not raise a result");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep && sts.sweep_last |=> !cmd.sweep && req_ready)
      else $error("clearing sweep did not stop at the last slot");

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !cmd.capture && !cmd.execute)
      else $error("item handled during the clearing sweep");
`endif

endmodule

// File: design/generational_handle_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Slot pool handing out index-plus-version handles through a free list.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  gha_pkg::req_type  (func, handle)
// rsp       out        rsp_valid / rsp_ready  gha_pkg::rsp_type  (status, handle, live)
//
// Each item has a capture step and an execute step: the accept edge reads
// the version and link memories at the head slot (allocate) or the handle's
// slot (free, exists), and the execute edge computes the result, updates
// the memories and the head, and loads the result register. After reset the
// block sweeps both memories, writing version 1 and the chained links, and
// holds req_ready low until the sweep is done. A result waiting on rsp_ready
// does not block the next accept; only the execute cycle stalls when the
// result register is still occupied.
//
module generational_handle_allocator_core #(
   parameter int SLOTS        = gha_pkg::SLOTS_DEF,
   parameter int VERSION_BITS = gha_pkg::VERSION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gha_pkg::rsp_type rsp_data
);

   gha_pkg::cmd_type cmd;
   gha_pkg::sts_type sts;

   // The controller sequences the sweep and the capture-and-execute item flow.
   gha_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the memories, the free-list head and the result.
   gha_datapath #(
      .SLOTS        (SLOTS),
      .VERSION_BITS (VERSION_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// File: tb/sv/gha_handle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_handle_checker
// Keeps its own copy of the slot pool, works out the result of every accepted
// request and compares it field by field with the result the block returns.
// ----------------------------------------------------------------------------
module gha_handle_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  gha_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  gha_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_count
);

   localparam int          POOL_SLOTS = gha_pkg::SLOTS_DEF;
   localparam logic [10:0] LIST_END   = 11'(POOL_SLOTS);

   // Shadow pool: per-slot version, free-list link and the list head.
   logic [15:0]      slot_ver  [POOL_SLOTS];
   logic [10:0]      next_free [POOL_SLOTS];
   logic [10:0]      free_top;
   gha_pkg::rsp_type expected_rsp_q [$];
   int               errors = 0;

   // Applies one request to the shadow pool and returns the answer it gives.
   function automatic gha_pkg::rsp_type apply_handle_op(input gha_pkg::req_type op);
      gha_pkg::rsp_type res;
      logic [9:0]       slot;
      res  = '0;
      slot = op.handle_index;
      case (op.func)
         gha_pkg::FUNC_ALLOC: begin
            if (free_top < LIST_END) begin
               res.out_index   = free_top[9:0];
               res.out_version = slot_ver[free_top[9:0]];
               free_top        = next_free[free_top[9:0]];
            end else begin
               res.status = gha_pkg::STATUS_FULL;
            end
         end
         gha_pkg::FUNC_FREE: begin
            if (slot_ver[slot] == op.handle_version) begin
               slot_ver[slot]  = slot_ver[slot] + 16'd1;
               next_free[slot] = free_top;
               free_top        = {1'b0, slot};
            end else begin
               res.status = gha_pkg::STATUS_STALE;
            end
         end
         gha_pkg::FUNC_EXISTS: begin
            res.handle_live = (slot_ver[slot] == op.handle_version);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      gha_pkg::rsp_type want;
      if (reset) begin
         for (int j = 0; j < POOL_SLOTS; j++) begin
            slot_ver[j]  = 16'd1;
            next_free[j] = 11'(j + 1);
         end
         free_top = '0;
         expected_rsp_q.delete();
      end else begin
         // The result is checked before the new request is predicted; a result
         // never belongs to a request accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  errors++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.out_index !== want.out_index) begin
                  errors++;
                  $display("%0t: out_index mismatch, expected %0d, actual %0d",
                           $time, want.out_index, rsp_data.out_index);
               end
               if (rsp_data.out_version !== want.out_version) begin
                  errors++;
                  $display("%0t: out_version mismatch, expected %0d, actual %0d",
                           $time, want.out_version, rsp_data.out_version);
               end
               if (rsp_data.handle_live !== want.handle_live) begin
                  errors++;
                  $display("%0t: handle_live mismatch, expected %0d, actual %0d",
                           $time, want.handle_live, rsp_data.handle_live);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(apply_handle_op(req_data));
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_rsp_q.size();
   end

endmodule

// File: tb/sv/generational_handle_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_core_tb
// Drives allocate, free and exists requests into the handle allocator and
// gives the verdict; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core_tb;

   // The block has no code for func 3; the testbench uses it as noise.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 10_000_000;

   // A handle as the block hands it out.
   typedef struct packed {
      logic [9:0]  slot;
      logic [15:0] ver;
   } slot_handle_type;

   // Patterns of the result receiver.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_TOGGLE,
      READY_RANDOM,
      READY_LONG
   } ready_mode_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   gha_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   gha_pkg::rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int burst_left  = 0;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_timer = 0;
   int             hold_left  = 0;

   // Handles returned by successful allocates, used to build well-formed
   // free and exists requests. issued_funcs pairs each result with its request.
   slot_handle_type live_handles [$];
   logic [1:0]      issued_funcs [$];

   always #6 clock = ~clock;

   generational_handle_allocator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   gha_handle_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Watchdog: a run that stalls or loses a result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: it switches at random between always ready, toggling, coin flips
   // and long stalls, so back-pressure hits the block in every phase of its
   // capture and execute steps.
   always @(posedge clock) begin
      if (mode_timer == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_timer <= $urandom_range(50, 400);
      end else begin
         mode_timer <= mode_timer - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_TOGGLE: rsp_ready <= ~rsp_ready;
         READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
         default: begin
            if (hold_left == 0) begin
               rsp_ready <= ~rsp_ready;
               hold_left <= rsp_ready ? $urandom_range(2, 20) : $urandom_range(1, 8);
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   // Collects the handles of successful allocates as their results leave.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && issued_funcs.size() > 0) begin
         if (issued_funcs.pop_front() == gha_pkg::FUNC_ALLOC &&
             rsp_data.status == gha_pkg::STATUS_OK) begin
            live_handles.push_back({rsp_data.out_index, rsp_data.out_version});
         end
      end
   end

   function automatic gha_pkg::req_type make_req(input logic [1:0] func,
                                                 input logic [9:0] slot,
                                                 input logic [15:0] ver);
      gha_pkg::req_type r;
      r.func           = func;
      r.handle_index   = slot;
      r.handle_version = ver;
      return r;
   endfunction

   // Builds one random request. Allocates and frees of live handles make up
   // the given shares; the rest is noise: exists queries, stale or wild frees,
   // frees of random slots at version 1, and the unused code.
   function automatic gha_pkg::req_type pick_random_req(input int alloc_pct,
                                                        input int free_pct);
      int              roll;
      int              pick;
      slot_handle_type h;
      roll = $urandom_range(0, 99);
      h    = {10'($urandom), 16'($urandom)};
      if (roll < alloc_pct) begin
         return make_req(gha_pkg::FUNC_ALLOC, 10'($urandom), 16'($urandom));
      end
      if (live_handles.size() > 0) begin
         pick = $urandom_range(0, live_handles.size() - 1);
         h    = live_handles[pick];
         if (roll < alloc_pct + free_pct) begin
            live_handles.delete(pick);
            return make_req(gha_pkg::FUNC_FREE, h.slot, h.ver);
         end
      end
      case ($urandom_range(0, 6))
         0:       return make_req(gha_pkg::FUNC_EXISTS, h.slot, h.ver);
         1:       return make_req(gha_pkg::FUNC_EXISTS, h.slot, h.ver + 16'd1);
         2:       return make_req(gha_pkg::FUNC_FREE, h.slot, h.ver - 16'd1);
         3:       return make_req(gha_pkg::FUNC_FREE, 10'($urandom), 16'($urandom));
         4:       return make_req(gha_pkg::FUNC_EXISTS, 10'($urandom), 16'($urandom));
         5:       return make_req(gha_pkg::FUNC_FREE, 10'($urandom), 16'd1);
         default: return make_req(FUNC_UNUSED, 10'($urandom), 16'($urandom));
      endcase
   endfunction

   // Sends one item. Items go out in bursts of random length; between bursts
   // the valid line may drop for a random gap. Some bursts are long, giving
   // stretches with no idling at all.
   task automatic send_req(input gha_pkg::req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      issued_funcs.push_back(item.func);
   endtask

   // Waits until every accepted item has had its result. The first edge lets
   // the checker's count take in the item accepted last.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      slot_handle_type target;
      logic [15:0]     ver_walk;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Exists on a fresh slot, extremes of index and version,
      // and stale frees before anything is allocated.
      send_req(make_req(gha_pkg::FUNC_EXISTS, 10'd0, 16'd1));
      send_req(make_req(gha_pkg::FUNC_EXISTS, 10'd0, 16'd0));
      send_req(make_req(gha_pkg::FUNC_EXISTS, 10'd1023, 16'hFFFF));
      send_req(make_req(gha_pkg::FUNC_FREE, 10'd5, 16'd2));
      send_req(make_req(gha_pkg::FUNC_FREE, 10'd1023, 16'hFFFF));
      // Allocate pops slots 0 and 1; freeing slot 0 bumps its version and puts
      // it back on top, so a second free with the old version is stale and the
      // next allocate returns slot 0 at version 2.
      send_req(make_req(gha_pkg::FUNC_ALLOC, 10'h3FF, 16'hFFFF));
      send_req(make_req(gha_pkg::FUNC_ALLOC, 10'd0, 16'd0));
      send_req(make_req(gha_pkg::FUNC_FREE, 10'd0, 16'd1));
      send_req(make_req(gha_pkg::FUNC_FREE, 10'd0, 16'd1));
      send_req(make_req(gha_pkg::FUNC_EXISTS, 10'd0, 16'd2));
      send_req(make_req(gha_pkg::FUNC_ALLOC, 10'd0, 16'd0));
      // Free of a slot that was never allocated: it is pushed although it
      // is still on the list, which then holds it twice.
      send_req(make_req(gha_pkg::FUNC_FREE, 10'd3, 16'd1));
      send_req(make_req(gha_pkg::FUNC_ALLOC, 10'd0, 16'd0));
      // The unused code must answer all zeros and leave the pool alone.
      send_req(make_req(FUNC_UNUSED, 10'd1023, 16'hFFFF));
      send_req(make_req(FUNC_UNUSED, 10'd0, 16'd0));
      send_req(make_req(gha_pkg::FUNC_FREE, 10'd1, 16'd1));
      send_req(make_req(gha_pkg::FUNC_EXISTS, 10'd1, 16'd1));
      send_req(make_req(gha_pkg::FUNC_EXISTS, 10'd1023, 16'd1));

      // Random part in three moods: balanced traffic, a fill that drives the
      // pool well past full, and a drain weighted towards freeing live handles.
      for (int n = 0; n < 150; n++) send_req(pick_random_req(40, 35));
      for (int n = 0; n < 1150; n++) send_req(pick_random_req(97, 1));
      for (int n = 0; n < 350; n++) send_req(pick_random_req(20, 65));

      // Repeated frees: one fresh handle is freed again and again, its version
      // stepping up each time while the list collects the slot many times over.
      // Repeated frees leave the list pointing at this slot, so this comes last.
      send_req(make_req(gha_pkg::FUNC_ALLOC, 10'd0, 16'd0));
      drain_results();
      if (live_handles.size() > 0) begin
         target   = live_handles.pop_back();
         ver_walk = target.ver;
         repeat (12) begin
            send_req(make_req(gha_pkg::FUNC_FREE, target.slot, ver_walk));
            ver_walk = ver_walk + 16'd1;
         end
         send_req(make_req(gha_pkg::FUNC_EXISTS, target.slot, ver_walk));
         send_req(make_req(gha_pkg::FUNC_EXISTS, target.slot, ver_walk - 16'd1));
         send_req(make_req(gha_pkg::FUNC_ALLOC, 10'd0, 16'd0));
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
